// File: rtl/msadpcm_pkg.sv
// Shared types, constants and arithmetic helpers of the MS ADPCM nibble decoder.
package msadpcm_pkg;

  localparam int MaxChannelsDef = 2;
  localparam int NumHdrCh       = 2;
  localparam int SampleW        = 16;
  localparam int CoefW          = 11;
  localparam int ProdW          = SampleW + CoefW;
  localparam int AccW           = ProdW + 1;
  localparam int NumCoefPairs   = 7;
  localparam int MinDelta       = 16;

  // Accumulator operations of the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    AccHold,
    AccLoad,
    AccAdd,
    AccDiv
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } mac_ctrl_t;

  // First coefficient of each predictor pair.
  function automatic logic signed [CoefW-1:0] coef_first(input logic [2:0] idx);
    logic signed [CoefW-1:0] c;
    unique case (idx)
      3'd0:    c = 11'sd256;
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      3'd6:    c = 11'sd392;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  // Second coefficient of each predictor pair.
  function automatic logic signed [CoefW-1:0] coef_second(input logic [2:0] idx);
    logic signed [CoefW-1:0] c;
    unique case (idx)
      3'd0:    c = 11'sd0;
      3'd1:    c = -11'sd256;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd64;
      3'd4:    c = 11'sd0;
      3'd5:    c = -11'sd208;
      3'd6:    c = -11'sd232;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  // Step size adaptation gain, indexed by the raw 4-bit code.
  function automatic logic signed [CoefW-1:0] adapt_gain(input logic [3:0] code);
    logic signed [CoefW-1:0] g;
    unique case (code)
      4'd4, 4'd12:               g = 11'sd307;
      4'd5, 4'd11:               g = 11'sd409;
      4'd6, 4'd10:               g = 11'sd512;
      4'd7, 4'd9:                g = 11'sd614;
      4'd8:                      g = 11'sd768;
      default:                   g = 11'sd230;
    endcase
    return g;
  endfunction

  // Division by 256 that truncates toward zero.
  function automatic logic signed [AccW-1:0] div256_tz(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] biased;
    biased = x + (x[AccW-1] ? AccW'(255) : AccW'(0));
    return biased >>> 8;
  endfunction

endpackage

// File: rtl/msadpcm_mac.sv
// Shared multiplier with product register and accumulator of the ADPCM decoder.
module msadpcm_mac (
  input  logic                                      clk_i,
  input  msadpcm_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [msadpcm_pkg::SampleW-1:0]    a_i,
  input  logic signed [msadpcm_pkg::CoefW-1:0]      b_i,
  output logic signed [msadpcm_pkg::ProdW-1:0]      prod_o,
  output logic signed [msadpcm_pkg::AccW-1:0]       acc_o
);
  import msadpcm_pkg::*;

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_comb begin
    unique case (ctrl_i.acc_op)
      AccHold: acc_d = acc_q;
      AccLoad: acc_d = AccW'(prod_q);
      AccAdd:  acc_d = acc_q + AccW'(prod_q);
      AccDiv:  acc_d = div256_tz(acc_q);
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// File: rtl/ms_adpcm_nibble_decoder.sv
// Top level of the MS ADPCM nibble decoder: sequencer, channel state and output register.
//
// This block decodes MS ADPCM for one or two interleaved channels. A header beat (tuser = 0)
// loads each active channel's predictor index, step size and two history samples, and then
// produces the older history sample of every channel followed by the newer one, with tlast
// on the final one. A code beat (tuser = 1) carries one byte; the high nibble is decoded
// first, then the low nibble, and with two channels the high nibble belongs to channel 0
// and the low nibble to channel 1. Every nibble needs four products (two prediction terms,
// the code times the step size, and the step size times its adaptation gain), and all of
// them go through one shared 16 x 11 multiplier, so each nibble passes through the states MUL1,
// MUL2, MUL3, DIV, ADD and WB, and both nibbles of a code beat are decoded before the block is
// ready again; write-back waits on a stalled output, as does the header state that emits a
// header beat's samples one at a time. The input is ready only while the sequencer is
// idle; the output register lets the next beat be accepted while the last sample still waits.
// The channel count register accepts a write in every cycle and should only be written while
// the block is idle; a count of zero acts as one and a count of three acts as two.
module ms_adpcm_nibble_decoder #(
  parameter int MAX_CHANNELS = msadpcm_pkg::MaxChannelsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: channel count.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: code_byte[7:0], ch0_predictor[15:8], ch0_step[31:16], ch0_newer[47:32],
  // ch0_older[63:48], ch1_predictor[71:64], ch1_step[87:72], ch1_newer[103:88],
  // ch1_older[119:104].
  input  logic [119:0] s_axis_tdata,
  // Bit 0: command.
  input  logic [0:0]   s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Bits 15:0: pcm_sample.
  output logic [15:0]  m_axis_tdata,
  // Bit 0: sample_channel.
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import msadpcm_pkg::*;

  localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MUL3 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  localparam logic       CmdHeader = 1'b0;

  localparam logic signed [AccW-1:0]    SatMax   = AccW'(32767);
  localparam logic signed [AccW-1:0]    SatMin   = -AccW'(32768);
  localparam logic signed [SampleW-1:0] DeltaMin = SampleW'(MinDelta);

  // Configuration and control state.
  logic [1:0] chan_cnt_q;
  logic [2:0] state_q, state_d;
  logic [1:0] hk_q;
  logic       nib_q;
  logic [7:0] byte_q;

  // Per-channel decoder state.
  logic        [2:0]         coef_q  [MAX_CHANNELS];
  logic signed [SampleW-1:0] step_q  [MAX_CHANNELS];
  logic signed [SampleW-1:0] newer_q [MAX_CHANNELS];
  logic signed [SampleW-1:0] older_q [MAX_CHANNELS];

  // Output register.
  logic               out_valid_q;
  logic [SampleW-1:0] out_data_q;
  logic               out_ch_q;
  logic               out_last_q;

  // Unpacked header fields.
  logic        [7:0]         hdr_pred  [NumHdrCh];
  logic signed [SampleW-1:0] hdr_step  [NumHdrCh];
  logic signed [SampleW-1:0] hdr_newer [NumHdrCh];
  logic signed [SampleW-1:0] hdr_older [NumHdrCh];

  assign hdr_pred[0]  = s_axis_tdata[15:8];
  assign hdr_step[0]  = s_axis_tdata[31:16];
  assign hdr_newer[0] = s_axis_tdata[47:32];
  assign hdr_older[0] = s_axis_tdata[63:48];
  assign hdr_pred[1]  = s_axis_tdata[71:64];
  assign hdr_step[1]  = s_axis_tdata[87:72];
  assign hdr_newer[1] = s_axis_tdata[103:88];
  assign hdr_older[1] = s_axis_tdata[119:104];

  // A count of two or three selects stereo, as long as the storage has a second channel.
  logic two_ch;
  assign two_ch = (MAX_CHANNELS > 1) && chan_cnt_q[1];

  logic in_acc, out_free, out_load;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // A new sample enters the output register from the header or the write-back state.
  assign out_load = out_free && ((state_q == S_HDR) || (state_q == S_WB));

  // Header emission: older samples of all channels first, then the newer ones.
  logic [ChW-1:0]     hdr_ch;
  logic               hdr_sel_newer, hdr_last;
  logic [SampleW-1:0] hdr_sample;
  assign hdr_ch        = two_ch ? ChW'(hk_q[0]) : '0;
  assign hdr_sel_newer = two_ch ? hk_q[1] : hk_q[0];
  assign hdr_last      = two_ch ? (hk_q == 2'd3) : (hk_q == 2'd1);
  assign hdr_sample    = hdr_sel_newer ? newer_q[hdr_ch] : older_q[hdr_ch];

  // Nibble being decoded and the channel it belongs to.
  logic [ChW-1:0] cur_ch;
  logic [3:0]     code;
  assign cur_ch = ChW'(nib_q && two_ch);
  assign code   = nib_q ? byte_q[3:0] : byte_q[7:4];

  // Shared multiply-accumulate unit and its operand selection.
  mac_ctrl_t                mac_ctrl;
  logic signed [SampleW-1:0] mac_a;
  logic signed [CoefW-1:0]   mac_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [AccW-1:0]    acc;

  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = AccHold;
    mac_a           = '0;
    mac_b           = '0;
    unique case (state_q)
      S_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = newer_q[cur_ch];
        mac_b           = coef_first(coef_q[cur_ch]);
      end
      S_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = AccLoad;
        mac_a           = older_q[cur_ch];
        mac_b           = coef_second(coef_q[cur_ch]);
      end
      S_MUL3: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = AccAdd;
        mac_a           = step_q[cur_ch];
        mac_b           = CoefW'($signed(code));
      end
      S_DIV: begin
        mac_ctrl.acc_op = AccDiv;
      end
      S_ADD: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = AccAdd;
        mac_a           = step_q[cur_ch];
        mac_b           = adapt_gain(code);
      end
      default: begin
      end
    endcase
  end

  msadpcm_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Write-back values: saturated sample and adapted step size.
  logic signed [SampleW-1:0] sample_sat;
  logic signed [AccW-1:0]    delta_div;
  logic signed [SampleW-1:0] delta_wrap, delta_new;

  always_comb begin
    if (acc > SatMax) begin
      sample_sat = SampleW'(SatMax);
    end else if (acc < SatMin) begin
      sample_sat = SampleW'(SatMin);
    end else begin
      sample_sat = acc[SampleW-1:0];
    end
  end

  // The quotient wraps to 16 bits before the lower limit is applied.
  assign delta_div  = div256_tz(AccW'(prod));
  assign delta_wrap = delta_div[SampleW-1:0];
  assign delta_new  = (delta_wrap < DeltaMin) ? DeltaMin : delta_wrap;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser[0] == CmdHeader) ? S_HDR : S_MUL1;
        end
      end
      S_HDR: begin
        if (out_free && hdr_last) begin
          state_d = S_IDLE;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_DIV;
      S_DIV:  state_d = S_ADD;
      S_ADD:  state_d = S_WB;
      S_WB: begin
        if (out_free) begin
          state_d = nib_q ? S_IDLE : S_MUL1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q  <= 2'd1;
      state_q     <= S_IDLE;
      hk_q        <= '0;
      nib_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        coef_q[c]  <= '0;
        step_q[c]  <= '0;
        newer_q[c] <= '0;
        older_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        chan_cnt_q <= cfg_data_i;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          hk_q  <= '0;
          nib_q <= 1'b0;
          if (in_acc) begin
            if (s_axis_tuser[0] == CmdHeader) begin
              // Mono leaves the second channel untouched.
              for (int c = 0; c < MAX_CHANNELS; c++) begin
                if (c == 0 || two_ch) begin
                  coef_q[c]  <= (hdr_pred[c] >= 8'(NumCoefPairs)) ? 3'd0 : hdr_pred[c][2:0];
                  step_q[c]  <= hdr_step[c];
                  newer_q[c] <= hdr_newer[c];
                  older_q[c] <= hdr_older[c];
                end
              end
            end else begin
              byte_q <= s_axis_tdata[7:0];
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            out_data_q  <= hdr_sample;
            out_ch_q    <= 1'(hdr_ch);
            out_last_q  <= hdr_last;
            hk_q        <= hk_q + 2'd1;
          end
        end
        S_WB: begin
          if (out_free) begin
            older_q[cur_ch] <= newer_q[cur_ch];
            newer_q[cur_ch] <= sample_sat;
            step_q[cur_ch]  <= delta_new;
            out_data_q      <= sample_sat;
            out_ch_q        <= 1'(cur_ch);
            out_last_q      <= nib_q;
            nib_q           <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ch_q;
  assign m_axis_tlast    = out_last_q;

endmodule

// File: tb/ms_adpcm_nibble_decoder_test.sv
// Self-checking testbench for the MS ADPCM nibble decoder with a built-in predictor.
`timescale 1ns / 100ps

module ms_adpcm_nibble_decoder_test;

  localparam logic CmdHeader = 1'b0;
  localparam logic CmdCode   = 1'b1;

  localparam int DrainCycles = 20;    // longer than one code beat plus the output register
  localparam int RandomItems = 230;

  // Input payload, declared from the top bit down so that it maps straight onto tdata.
  typedef struct packed {
    logic signed [15:0] ch1_older;
    logic signed [15:0] ch1_newer;
    logic signed [15:0] ch1_step;
    logic        [7:0]  ch1_pred;
    logic signed [15:0] ch0_older;
    logic signed [15:0] ch0_newer;
    logic signed [15:0] ch0_step;
    logic        [7:0]  ch0_pred;
    logic        [7:0]  code_byte;
  } adpcm_beat_t;

  typedef struct {
    logic signed [15:0] pcm;
    logic               chan;
    logic               last;
  } pcm_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;   // code_byte, ch0 pred/step/newer/older, ch1 pred/step/newer/older
  logic [0:0]   s_axis_tuser;   // command
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;   // pcm_sample
  logic [0:0]   m_axis_tuser;   // sample_channel
  logic         m_axis_tlast;

  ms_adpcm_nibble_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Decoder model: its own copy of the channel state and of the channel count register.
  // ---------------------------------------------------------------------------------------
  logic        [1:0]  chan_count_reg;
  logic        [2:0]  pair_sel   [2];
  logic signed [15:0] delta      [2];
  logic signed [15:0] hist_newer [2];
  logic signed [15:0] hist_older [2];

  // Coefficient pairs and the step adaptation gains, indexed by the raw nibble.
  int first_coef  [7]  = '{256, 512, 0, 192, 240, 460, 392};
  int second_coef [7]  = '{0, -256, 0, 64, 0, -208, -232};
  int step_gain   [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                           768, 614, 512, 409, 307, 230, 230, 230};

  pcm_result_t expected_pcm[$];
  int          mismatches = 0;
  bit          calm = 1'b0;     // no idling on either side while set

  // A count of zero acts as one and a count of three acts as two.
  function automatic int live_channels();
    if (chan_count_reg == 2'd0) return 1;
    if (chan_count_reg >= 2'd2) return 2;
    return 1;
  endfunction

  function automatic logic signed [15:0] decode_nibble(input int ch, input logic [3:0] code);
    int pred;
    int sum;
    int scaled;
    int sel;
    logic signed [15:0] sample;
    logic [31:0] scaled_bits;
    sel = (pair_sel[ch] >= 3'd7) ? 0 : int'(pair_sel[ch]);
    // Signed division in SystemVerilog truncates toward zero.
    pred = (int'(hist_newer[ch]) * first_coef[sel] +
            int'(hist_older[ch]) * second_coef[sel]) / 256;
    sum = pred + int'($signed(code)) * int'(delta[ch]);
    if (sum > 32767)       sample = 16'sh7fff;
    else if (sum < -32768) sample = 16'sh8000;
    else                   sample = sum[15:0];
    hist_older[ch] = hist_newer[ch];
    hist_newer[ch] = sample;
    // The scaled step wraps to 16 bits before the floor of 16 applies.
    scaled = (int'(delta[ch]) * step_gain[code]) / 256;
    scaled_bits = scaled;
    scaled = int'($signed(scaled_bits[15:0]));
    delta[ch] = (scaled < 16) ? 16'sd16 : scaled_bits[15:0];
    return sample;
  endfunction

  function automatic void push_pcm(input logic signed [15:0] pcm, input int ch,
                                   input logic last);
    pcm_result_t r;
    r.pcm  = pcm;
    r.chan = ch[0];
    r.last = last;
    expected_pcm.push_back(r);
  endfunction

  function automatic void predict_beat(input logic cmd, input adpcm_beat_t b);
    int chans;
    int sec;
    logic signed [15:0] s;
    chans = live_channels();
    if (cmd == CmdHeader) begin
      pair_sel[0]   = (b.ch0_pred >= 8'd7) ? 3'd0 : b.ch0_pred[2:0];
      delta[0]      = b.ch0_step;
      hist_newer[0] = b.ch0_newer;
      hist_older[0] = b.ch0_older;
      // In mono the channel 1 state keeps whatever it held.
      if (chans == 2) begin
        pair_sel[1]   = (b.ch1_pred >= 8'd7) ? 3'd0 : b.ch1_pred[2:0];
        delta[1]      = b.ch1_step;
        hist_newer[1] = b.ch1_newer;
        hist_older[1] = b.ch1_older;
      end
      for (int c = 0; c < chans; c++) push_pcm(hist_older[c], c, 1'b0);
      for (int c = 0; c < chans; c++) push_pcm(hist_newer[c], c, c == chans - 1);
    end else begin
      sec = (chans == 2) ? 1 : 0;
      s = decode_nibble(0, b.code_byte[7:4]);
      push_pcm(s, 0, 1'b0);
      s = decode_nibble(sec, b.code_byte[3:0]);
      push_pcm(s, sec, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Output side: random back-pressure bursts, and a checker on every accepted beat.
  // ---------------------------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pcm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pcm.size() == 0) begin
        $error("unexpected output beat: pcm_sample %0d, channel %0d",
               $signed(m_axis_tdata), m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_pcm.pop_front();
        if (m_axis_tdata !== want.pcm) begin
          $error("pcm_sample: expected %0d, got %0d", want.pcm, $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.chan) begin
          $error("sample_channel: expected %0d, got %0d", want.chan, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side. Every task here starts and ends at a falling edge.
  // ---------------------------------------------------------------------------------------
  task automatic send_beat(input logic cmd, input adpcm_beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat(cmd, b);
    @(negedge clk_i);
  endtask

  // Lowers tvalid once the stream pauses; never called in the step of another send.
  task automatic stop_stream();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_pcm.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_channel_count(input logic [1:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    chan_count_reg = count;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic adpcm_beat_t random_beat();
    adpcm_beat_t b;
    b = 120'({$urandom, $urandom, $urandom, $urandom});
    return b;
  endfunction

  task automatic send_code(input logic [7:0] code_byte);
    adpcm_beat_t b;
    b = random_beat();
    b.code_byte = code_byte;
    send_beat(CmdCode, b);
  endtask

  task automatic send_header(input logic [7:0] p0, input logic [15:0] s0, input logic [15:0] n0,
                             input logic [15:0] o0, input logic [7:0] p1, input logic [15:0] s1,
                             input logic [15:0] n1, input logic [15:0] o1);
    adpcm_beat_t b;
    b = random_beat();
    b.ch0_pred = p0;  b.ch0_step = s0;  b.ch0_newer = n0;  b.ch0_older = o0;
    b.ch1_pred = p1;  b.ch1_step = s1;  b.ch1_newer = n1;  b.ch1_older = o1;
    send_beat(CmdHeader, b);
  endtask

  // Mostly plausible header values, with the full field ranges mixed in.
  function automatic adpcm_beat_t random_header();
    adpcm_beat_t b;
    b = random_beat();
    if ($urandom_range(0, 3) != 0) begin
      b.ch0_pred = 8'($urandom_range(0, 6));
      b.ch1_pred = 8'($urandom_range(0, 6));
    end
    if ($urandom_range(0, 2) != 0) begin
      b.ch0_step = 16'($urandom_range(16, 2000));
      b.ch1_step = 16'($urandom_range(16, 2000));
    end
    if ($urandom_range(0, 2) != 0) begin
      b.ch0_newer = 16'($signed(12'($urandom)));
      b.ch0_older = 16'($signed(12'($urandom)));
      b.ch1_newer = 16'($signed(12'($urandom)));
      b.ch1_older = 16'($signed(12'($urandom)));
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Code beats straight after reset decode from the all-zero channel state.
  task automatic test_code_before_header();
    send_code(8'h7f);
    send_code(8'h80);
    stop_stream();
    wait_drained();
  endtask

  // Mono headers with extreme fields, out-of-range predictor indexes, a negative step,
  // every nibble value and a step that overflows 16 bits after adaptation.
  task automatic test_mono_extremes();
    write_channel_count(2'd1);
    send_header(8'd1, 16'sd20, 16'sh7fff, 16'sh8000, 8'hff, 16'hffff, 16'hffff, 16'hffff);
    send_code(8'h01);
    send_code(8'h23);
    send_header(8'd7, -16'sd100, 16'sh8000, 16'sh7fff, 8'd0, 16'd0, 16'd0, 16'd0);
    send_code(8'h45);
    send_code(8'h67);
    send_header(8'hff, 16'sh8000, 16'sd0, 16'sd0, 8'd3, 16'sd5, 16'sd5, 16'sd5);
    send_code(8'h89);
    send_code(8'hab);
    send_header(8'd6, 16'sh7fff, 16'sh7fff, 16'sh8000, 8'd5, 16'sd1, 16'sd1, 16'sd1);
    send_code(8'h88);
    send_code(8'hcd);
    send_code(8'hef);
    stop_stream();
    wait_drained();
  endtask

  // Two channels: the high nibble goes to channel 0 and the low nibble to channel 1.
  task automatic test_stereo();
    write_channel_count(2'd2);
    send_header(8'd5, 16'sd300, -16'sd1200, 16'sd900, 8'd1, 16'sd4000, 16'sh7fff, 16'sh8000);
    send_code(8'h7f);
    send_code(8'h08);
    send_code(8'h3c);
    stop_stream();
    wait_drained();
  endtask

  // A count of zero behaves as mono and a count of three as stereo.
  task automatic test_count_aliases();
    write_channel_count(2'd0);
    send_header(8'd2, 16'sd64, 16'sd10, -16'sd10, 8'd4, 16'sd99, 16'sd99, 16'sd99);
    send_code(8'h5a);
    stop_stream();
    wait_drained();
    write_channel_count(2'd3);
    send_header(8'd4, 16'sd64, 16'sd10, -16'sd10, 8'd6, 16'sd77, -16'sd300, 16'sd200);
    send_code(8'ha5);
    stop_stream();
    wait_drained();
  endtask

  // Mostly well-formed blocks (a header and a run of code bytes), with some stray beats.
  // The segments that start within the last 50 items run without idling on either side.
  task automatic test_random_blocks();
    int sent;
    int seg_end;
    int run;
    adpcm_beat_t b;
    sent = 0;
    while (sent < RandomItems) begin
      write_channel_count(2'($urandom_range(0, 3)));
      if (sent >= RandomItems - 50) calm = 1'b1;
      seg_end = sent + $urandom_range(25, 50);
      while (sent < seg_end && sent < RandomItems) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(logic'($urandom_range(0, 1)), random_beat());
          sent++;
        end else begin
          send_beat(CmdHeader, random_header());
          run = $urandom_range(1, 10);
          for (int i = 0; i < run; i++) send_code(8'($urandom_range(0, 255)));
          sent += run + 1;
        end
      end
      stop_stream();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 2'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdHeader;
    m_axis_tready = 1'b0;
    chan_count_reg = 2'd1;
    for (int c = 0; c < 2; c++) begin
      pair_sel[c]   = 3'd0;
      delta[c]      = 16'sd0;
      hist_newer[c] = 16'sd0;
      hist_older[c] = 16'sd0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_code_before_header();
    test_mono_extremes();
    test_stereo();
    test_count_aliases();
    test_random_blocks();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // The slowest correct run stays well under a quarter of this.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
